FILE: design/cre_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the character range expander.
// Used by the controller, the datapath and the top level; depends on nothing.

package cre_pkg;

   // ASCII dash, the range operator.
   localparam logic [7:0] DASH = 8'h2D;

   // Character classes; only equal, nonzero classes form a range.
   localparam logic [1:0] CLS_NONE  = 2'd0;
   localparam logic [1:0] CLS_UPPER = 2'd1;
   localparam logic [1:0] CLS_LOWER = 2'd2;
   localparam logic [1:0] CLS_DIGIT = 2'd3;

   // Decision slots of one item: the settled older position, then the two
   // positions flushed at the end of a string.
   localparam logic [1:0] SLOT_OLD  = 2'd0;
   localparam logic [1:0] SLOT_MID  = 2'd1;
   localparam logic [1:0] SLOT_LAST = 2'd2;

   // Outcome of deciding one position.
   localparam logic [2:0] OUT_SKIP  = 3'd0;
   localparam logic [2:0] OUT_NONE  = 3'd1;
   localparam logic [2:0] OUT_ONE   = 3'd2;
   localparam logic [2:0] OUT_MIS   = 3'd3;
   localparam logic [2:0] OUT_RANGE = 3'd4;

   // Source of an emitted byte.
   localparam logic [1:0] SEL_CUR  = 2'd0;
   localparam logic [1:0] SEL_PREV = 2'd1;
   localparam logic [1:0] SEL_DASH = 2'd2;
   localparam logic [1:0] SEL_RUN  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       emit;
      logic [1:0] emit_sel;
      logic       run_load;
      logic       run_step;
      logic       skip_clear;
      logic       skip_set;
      logic       finish;
      logic [1:0] slot;
   } cre_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] outcome;
      logic [2:0] slot_valid;
      logic       push_ok;
      logic       run_done;
   } cre_sts_type;

   // Classifies a byte as upper-case letter, lower-case letter, digit or none.
   function automatic logic [1:0] char_class(input logic [7:0] c);
      logic [1:0] cls;
      cls = CLS_NONE;
      if (c >= 8'h41 && c <= 8'h5A) begin
         cls = CLS_UPPER;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         cls = CLS_LOWER;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         cls = CLS_DIGIT;
      end
      return cls;
   endfunction

endpackage

FILE: design/cre_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the request and response channels.
// Standalone; widths follow the fixed field sizes of the block.

interface cre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       string_end;

   modport source (output valid, output in_char, output string_end, input ready);
   modport sink   (input valid, input in_char, input string_end, output ready);
endinterface

interface cre_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       mismatch;
   logic       string_done;
   logic       last_of_run;

   modport source (output valid, output out_char, output mismatch,
                   output string_done, output last_of_run, input ready);
   modport sink   (input valid, input out_char, input mismatch,
                   input string_done, input last_of_run, output ready);
endinterface

FILE: design/character_range_expander.sv
`timescale 1ns / 1ps
// Character range expander: turns "a-e" style ranges in a byte stream into
// the full runs. Depends on cre_pkg, cre_if, cre_ctrl and cre_dp.
//
// Usage:
//   req_bus carries one byte of the string per transfer, string_end set on
//   the final byte. rsp_bus carries the expanded bytes; last_of_run marks the
//   last byte caused by one request, string_done the last byte of a string.
//   A request that decides no position gives no response.
//   Flow: a request is taken only while the controller is idle. The
//   controller then decides each decision slot in turn (at most one, or up
//   to three on the final byte), emits the byte before the dash and then
//   the dash for a mismatch, emits the n bytes of a range one by one and
//   closes the item. The single output port of the hold stage limits the
//   output to one byte per cycle; the controller waits while output stalls.
//   Reset (synchronous, active high) clears the lookback window, the pending
//   counts and any byte in flight.
//   When the receiver stalls, the output register and one hold byte keep
//   their data and the controller waits; nothing is dropped.

module character_range_expander (
   input  logic          clock,
   input  logic          reset,
   cre_req_if.sink       req_bus,
   cre_rsp_if.source     rsp_bus
);

   cre_pkg::cre_cmd_type cmd;
   cre_pkg::cre_sts_type sts;

   // Controller.
   cre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath.
   cre_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .in_char     (req_bus.in_char),
      .string_end  (req_bus.string_end),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .out_char    (rsp_bus.out_char),
      .mismatch    (rsp_bus.mismatch),
      .string_done (rsp_bus.string_done),
      .last_of_run (rsp_bus.last_of_run)
   );

endmodule

FILE: design/cre_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the character range expander.
// Depends on cre_pkg for the command and status structs and their codes.

module cre_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cre_pkg::cre_sts_type sts,
   output cre_pkg::cre_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVAL   = 3'd1;
   localparam logic [2:0] S_RUN    = 3'd2;
   localparam logic [2:0] S_MIS2   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] slot_ff, slot_in;
   logic       next_ok;
   logic [1:0] next_slot;

   // Find the next slot that has a position to decide.
   always_comb begin
      next_ok   = 1'b0;
      next_slot = cre_pkg::SLOT_LAST;
      case (slot_ff)
         cre_pkg::SLOT_OLD: begin
            if (sts.slot_valid[cre_pkg::SLOT_MID]) begin
               next_ok   = 1'b1;
               next_slot = cre_pkg::SLOT_MID;
            end else if (sts.slot_valid[cre_pkg::SLOT_LAST]) begin
               next_ok   = 1'b1;
               next_slot = cre_pkg::SLOT_LAST;
            end
         end
         cre_pkg::SLOT_MID: begin
            if (sts.slot_valid[cre_pkg::SLOT_LAST]) begin
               next_ok   = 1'b1;
               next_slot = cre_pkg::SLOT_LAST;
            end
         end
         default: begin
            next_ok = 1'b0;
         end
      endcase
   end

   // Sequencing of the decisions of one item and the final flush.
   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.slot  = slot_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               slot_in    = cre_pkg::SLOT_OLD;
               state_in   = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!sts.slot_valid[slot_ff]) begin
               state_in = next_ok ? S_EVAL : S_FINISH;
               slot_in  = next_slot;
            end else begin
               case (sts.outcome)
                  cre_pkg::OUT_SKIP: begin
                     cmd.skip_clear = 1'b1;
                     state_in       = next_ok ? S_EVAL : S_FINISH;
                     slot_in        = next_slot;
                  end
                  cre_pkg::OUT_ONE: begin
                     if (sts.push_ok) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = cre_pkg::SEL_CUR;
                        state_in     = next_ok ? S_EVAL : S_FINISH;
                        slot_in      = next_slot;
                     end
                  end
                  cre_pkg::OUT_MIS: begin
                     if (sts.push_ok) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = cre_pkg::SEL_PREV;
                        state_in     = S_MIS2;
                     end
                  end
                  cre_pkg::OUT_RANGE: begin
                     cmd.run_load = 1'b1;
                     state_in     = S_RUN;
                  end
                  default: begin
                     state_in = next_ok ? S_EVAL : S_FINISH;
                     slot_in  = next_slot;
                  end
               endcase
            end
         end
         S_RUN: begin
            if (sts.push_ok) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = cre_pkg::SEL_RUN;
               if (sts.run_done) begin
                  cmd.skip_set = 1'b1;
                  state_in     = next_ok ? S_EVAL : S_FINISH;
                  slot_in      = next_slot;
               end else begin
                  cmd.run_step = 1'b1;
               end
            end
         end
         S_MIS2: begin
            if (sts.push_ok) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = cre_pkg::SEL_DASH;
               state_in     = next_ok ? S_EVAL : S_FINISH;
               slot_in      = next_slot;
            end
         end
         S_FINISH: begin
            if (sts.push_ok) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         slot_ff  <= cre_pkg::SLOT_OLD;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

FILE: design/cre_dp.sv
`timescale 1ns / 1ps
// Datapath of the character range expander: lookback window, run counter,
// hold stage and output register. Depends on cre_pkg.

module cre_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  cre_pkg::cre_cmd_type cmd,
   output cre_pkg::cre_sts_type sts,
   input  logic [7:0]           in_char,
   input  logic                 string_end,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [7:0]           out_char,
   output logic                 mismatch,
   output logic                 string_done,
   output logic                 last_of_run
);

   logic [7:0] win0_ff, win1_ff, win2_ff;
   logic [1:0] seen_ff, pend_ff;
   logic       skip_ff;
   logic [7:0] char_ff;
   logic       end_ff;
   logic [7:0] run_v_ff;
   logic       run_up_ff;
   logic       hold_vld_ff;
   logic [7:0] hold_char_ff;
   logic       hold_mis_ff;
   logic       out_vld_ff;
   logic [7:0] out_char_ff;
   logic       out_mis_ff, out_done_ff, out_last_ff;

   logic [7:0] prev_c, cur_c, next_c;
   logic       has_prev, has_next, has_next2;
   logic [7:0] emit_char;
   logic       emit_mis;
   logic       out_free, move;
   logic [2:0] outcome_c;
   logic [2:0] slot_vld_c;
   logic       push_ok_c;
   logic       run_done_c;

   // Operands of the position decided in the current slot.
   always_comb begin
      prev_c    = win0_ff;
      cur_c     = char_ff;
      next_c    = 8'h00;
      has_prev  = (seen_ff != 2'd0);
      has_next  = 1'b0;
      has_next2 = 1'b0;
      case (cmd.slot)
         cre_pkg::SLOT_OLD: begin
            prev_c    = win2_ff;
            cur_c     = win1_ff;
            next_c    = win0_ff;
            has_prev  = (seen_ff == 2'd3);
            has_next  = 1'b1;
            has_next2 = 1'b1;
         end
         cre_pkg::SLOT_MID: begin
            prev_c   = win1_ff;
            cur_c    = win0_ff;
            next_c   = char_ff;
            has_prev = (seen_ff >= 2'd2);
            has_next = 1'b1;
         end
         default: begin
            prev_c = win0_ff;
         end
      endcase
   end

   // Decision for the current position.
   always_comb begin
      if (skip_ff) begin
         outcome_c = cre_pkg::OUT_SKIP;
      end else if (cur_c == cre_pkg::DASH) begin
         if (!has_prev || !has_next) begin
            outcome_c = cre_pkg::OUT_ONE;
         end else if (cre_pkg::char_class(prev_c) != cre_pkg::CLS_NONE &&
                      cre_pkg::char_class(prev_c) == cre_pkg::char_class(next_c)) begin
            outcome_c = cre_pkg::OUT_RANGE;
         end else begin
            outcome_c = cre_pkg::OUT_MIS;
         end
      end else if (has_next && next_c == cre_pkg::DASH && has_next2) begin
         outcome_c = cre_pkg::OUT_NONE;
      end else begin
         outcome_c = cre_pkg::OUT_ONE;
      end
   end

   // Slots that hold a position, stall check and end of run.
   assign slot_vld_c = {end_ff, end_ff && (pend_ff != 2'd0), (pend_ff == 2'd2)};
   assign out_free   = !out_vld_ff || rsp_ready;
   assign push_ok_c  = !hold_vld_ff || out_free;
   assign run_done_c = (run_v_ff == next_c);
   assign move       = hold_vld_ff && (cmd.emit || cmd.finish);

   // Status toward the controller.
   assign sts = '{outcome: outcome_c, slot_valid: slot_vld_c, push_ok: push_ok_c,
                  run_done: run_done_c};

   // Byte to emit.
   always_comb begin
      case (cmd.emit_sel)
         cre_pkg::SEL_CUR: begin
            emit_char = cur_c;
            emit_mis  = 1'b0;
         end
         cre_pkg::SEL_PREV: begin
            emit_char = prev_c;
            emit_mis  = 1'b1;
         end
         cre_pkg::SEL_DASH: begin
            emit_char = cre_pkg::DASH;
            emit_mis  = 1'b1;
         end
         default: begin
            emit_char = run_v_ff;
            emit_mis  = 1'b0;
         end
      endcase
   end

   // Input capture and run counter.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         char_ff <= in_char;
         end_ff  <= string_end;
      end
      if (cmd.run_load) begin
         run_v_ff  <= prev_c;
         run_up_ff <= (next_c > prev_c);
      end else if (cmd.run_step) begin
         run_v_ff <= run_up_ff ? run_v_ff + 8'd1 : run_v_ff - 8'd1;
      end
   end

   // Lookback window and string state.
   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff <= 8'h00;
         win1_ff <= 8'h00;
         win2_ff <= 8'h00;
         seen_ff <= 2'd0;
         pend_ff <= 2'd0;
         skip_ff <= 1'b0;
      end else if (cmd.finish) begin
         if (end_ff) begin
            win0_ff <= 8'h00;
            win1_ff <= 8'h00;
            win2_ff <= 8'h00;
            seen_ff <= 2'd0;
            pend_ff <= 2'd0;
            skip_ff <= 1'b0;
         end else begin
            win2_ff <= win1_ff;
            win1_ff <= win0_ff;
            win0_ff <= char_ff;
            if (seen_ff != 2'd3) begin
               seen_ff <= seen_ff + 2'd1;
            end
            if (pend_ff != 2'd2) begin
               pend_ff <= pend_ff + 2'd1;
            end
         end
      end else if (cmd.skip_set) begin
         skip_ff <= 1'b1;
      end else if (cmd.skip_clear) begin
         skip_ff <= 1'b0;
      end
   end

   // Hold stage: a byte waits here until it is known whether it is the
   // last one of the item.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else if (cmd.emit) begin
         hold_vld_ff <= 1'b1;
      end else if (cmd.finish) begin
         hold_vld_ff <= 1'b0;
      end
      if (cmd.emit) begin
         hold_char_ff <= emit_char;
         hold_mis_ff  <= emit_mis;
      end
   end

   // Output register toward the response channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (move) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
      if (move) begin
         out_char_ff <= hold_char_ff;
         out_mis_ff  <= hold_mis_ff;
         out_done_ff <= cmd.finish && end_ff;
         out_last_ff <= cmd.finish;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign out_char    = out_char_ff;
   assign mismatch    = out_mis_ff;
   assign string_done = out_done_ff;
   assign last_of_run = out_last_ff;

endmodule

FILE: design/cre_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the character range expander, bound to the top level.
// Depends only on the top level's channel signals.

module cre_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_string_done,
   input logic       rsp_last_of_run
);

   // A stalled response keeps its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char))
      else $error("stalled response changed");

   // The end of a string is also the end of its request's bytes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_done |-> rsp_last_of_run)
      else $error("string_done without last_of_run");

   // One request at a time: no transfer right after a transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind character_range_expander cre_checker u_cre_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_char    (rsp_bus.out_char),
   .rsp_string_done (rsp_bus.string_done),
   .rsp_last_of_run (rsp_bus.last_of_run)
);
